FILE: hw/rtl/lcdnw_pkg.sv
// Shared types, codes and constants for the character LCD number writer.
package lcdnw_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 4;

  localparam logic [7:0] ADDR_BASE = 8'h80;
  localparam logic [7:0] ROW1_OFS  = 8'h40;
  localparam logic [7:0] CMD_FUNC  = 8'h38;
  localparam logic [7:0] CMD_DISP  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY = 8'h06;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [COUNT_W-1:0] INIT_LEN = 4'd4;
  localparam logic [COUNT_W-1:0] CHAR_LEN = 4'd1;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_CHAR     = 2'd1,
    OP_UNSIGNED = 2'd2,
    OP_SIGNED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_CHAR = 2'd1,
    JOB_NUM  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    logic                 has_addr;
    logic [7:0]           addr;
    logic                 has_sign;
    logic [7:0]           sign_ch;
    logic [7:0]           data_ch;
    logic [VALUE_W-1:0]   mag;
    logic [COUNT_W-1:0]   len;
  } job_t;

  // init commands, indexed by bytes remaining
  function automatic logic [7:0] init_cmd(input logic [COUNT_W-1:0] remain);
    logic [7:0] cmd;
    unique case (remain)
      4'd4:    cmd = CMD_FUNC;
      4'd3:    cmd = CMD_DISP;
      4'd2:    cmd = CMD_ENTRY;
      default: cmd = CMD_CLEAR;
    endcase
    return cmd;
  endfunction

endpackage

FILE: hw/rtl/lcdnw_if.sv
// Request and LCD write channel interfaces.
interface lcdnw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  row;
  logic [5:0]  column;
  logic [31:0] value;
  logic [3:0]  digit_count;

  modport source (output valid, op, row, column, value, digit_count, input ready);
  modport sink   (input valid, op, row, column, value, digit_count, output ready);
endinterface

interface lcdnw_wr_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] lcd_byte;
  logic       last;

  modport source (output valid, is_data, lcd_byte, last, input ready);
  modport sink   (input valid, is_data, lcd_byte, last, output ready);
endinterface

FILE: hw/rtl/lcdnw_front.sv
// Front end: classifies a display request into a byte-generation job.
module lcdnw_front #(
  parameter int MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
  input  logic [1:0]          op,
  input  logic [7:0]          row,
  input  logic [5:0]          column,
  input  logic [31:0]         value,
  input  logic [3:0]          digit_count,
  output lcdnw_pkg::job_t     job
);

  logic [lcdnw_pkg::COUNT_W-1:0] cnt_sat;
  logic [7:0]                    row_ofs;

  always_comb begin
    if (int'(digit_count) > MAX_DIGITS) cnt_sat = lcdnw_pkg::COUNT_W'(MAX_DIGITS);
    else                                cnt_sat = digit_count;
    row_ofs = (row == 8'd1) ? lcdnw_pkg::ROW1_OFS : 8'd0;

    job.kind     = lcdnw_pkg::JOB_NUM;
    job.has_addr = (row == 8'd0) || (row == 8'd1);
    job.addr     = lcdnw_pkg::ADDR_BASE + row_ofs + {2'b00, column};
    job.has_sign = 1'b0;
    job.sign_ch  = lcdnw_pkg::CHAR_PLUS;
    job.data_ch  = value[7:0];
    job.mag      = value;
    job.len      = cnt_sat;

    unique case (lcdnw_pkg::op_t'(op))
      lcdnw_pkg::OP_INIT: begin
        job.kind     = lcdnw_pkg::JOB_INIT;
        job.has_addr = 1'b0;
        job.len      = lcdnw_pkg::INIT_LEN;
      end
      lcdnw_pkg::OP_CHAR: begin
        job.kind = lcdnw_pkg::JOB_CHAR;
        job.len  = lcdnw_pkg::CHAR_LEN;
      end
      lcdnw_pkg::OP_UNSIGNED: begin
        job.kind = lcdnw_pkg::JOB_NUM;
      end
      default: begin
        job.kind     = lcdnw_pkg::JOB_NUM;
        job.has_sign = 1'b1;
        if (value[31]) begin
          job.sign_ch = lcdnw_pkg::CHAR_MINUS;
          job.mag     = ~value + 32'd1;
        end
      end
    endcase
  end

endmodule

FILE: hw/rtl/lcdnw_fifo.sv
// Two-entry job queue between front end and byte sequencer.
module lcdnw_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdnw_pkg::job_t wr_job,
  output logic            full,
  input  logic            pop,
  output lcdnw_pkg::job_t rd_job,
  output logic            empty
);

  lcdnw_pkg::job_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_job;
  end

endmodule

FILE: hw/rtl/lcdnw_back.sv
// Byte sequencer: BCD conversion and ordered LCD byte writes.
module lcdnw_back #(
  parameter int MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lcdnw_pkg::job_t  job,
  input  logic             q_empty,
  output logic             pop,
  lcdnw_wr_if.source       wr
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int VW    = lcdnw_pkg::VALUE_W;
  localparam logic [4:0] CONV_LAST = 5'(VW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_ADDR,
    S_SIGN,
    S_DATA
  } state_t;

  state_t                         state_r;
  lcdnw_pkg::job_kind_t           kind_r;
  logic                           has_addr_r;
  logic [7:0]                     addr_r;
  logic                           has_sign_r;
  logic [7:0]                     sign_r;
  logic [7:0]                     data_r;
  logic [lcdnw_pkg::COUNT_W-1:0]  idx_r;
  logic [VW-1:0]                  bin_r;
  logic [BCD_W-1:0]               bcd_r;
  logic [4:0]                     conv_cnt_r;
  logic                           out_valid_r;
  logic                           out_is_data_r;
  logic [7:0]                     out_byte_r;
  logic                           out_last_r;

  logic [BCD_W-1:0]               bcd_adj;
  logic [BCD_W-1:0]               bcd_nxt;
  logic [3:0]                     digit_sel;
  logic [7:0]                     data_byte;
  logic                           emit_ok;
  logic                           emit_now;

  function automatic state_t first_state(input logic a, input logic s,
                                         input logic [lcdnw_pkg::COUNT_W-1:0] n);
    state_t st;
    if (a)            st = S_ADDR;
    else if (s)       st = S_SIGN;
    else if (n != 0)  st = S_DATA;
    else              st = S_IDLE;
    return st;
  endfunction

  assign pop      = (state_r == S_IDLE) && !q_empty;
  assign emit_ok  = !out_valid_r || wr.ready;
  assign emit_now = emit_ok &&
                    ((state_r == S_ADDR) || (state_r == S_SIGN) || (state_r == S_DATA));

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      else                         bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
    end
    bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VW-1]};

    digit_sel = 4'd0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (int'(idx_r) == k + 1) digit_sel = bcd_r[4*k +: 4];
    end

    case (kind_r)
      lcdnw_pkg::JOB_INIT: data_byte = lcdnw_pkg::init_cmd(idx_r);
      lcdnw_pkg::JOB_CHAR: data_byte = data_r;
      default:             data_byte = lcdnw_pkg::CHAR_ZERO + {4'd0, digit_sel};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (wr.ready && !emit_now) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            kind_r     <= job.kind;
            has_addr_r <= job.has_addr;
            addr_r     <= job.addr;
            has_sign_r <= job.has_sign;
            sign_r     <= job.sign_ch;
            data_r     <= job.data_ch;
            idx_r      <= job.len;
            bin_r      <= job.mag;
            bcd_r      <= '0;
            conv_cnt_r <= 5'd0;
            if (job.kind == lcdnw_pkg::JOB_NUM) state_r <= S_CONV;
            else state_r <= first_state(job.has_addr, job.has_sign, job.len);
          end
        end
        S_CONV: begin
          bcd_r      <= bcd_nxt;
          bin_r      <= {bin_r[VW-2:0], 1'b0};
          conv_cnt_r <= conv_cnt_r + 5'd1;
          if (conv_cnt_r == CONV_LAST)
            state_r <= first_state(has_addr_r, has_sign_r, idx_r);
        end
        S_ADDR: begin
          if (emit_ok) begin
            out_valid_r   <= 1'b1;
            out_is_data_r <= 1'b0;
            out_byte_r    <= addr_r;
            out_last_r    <= !has_sign_r && (idx_r == 0);
            state_r       <= first_state(1'b0, has_sign_r, idx_r);
          end
        end
        S_SIGN: begin
          if (emit_ok) begin
            out_valid_r   <= 1'b1;
            out_is_data_r <= 1'b1;
            out_byte_r    <= sign_r;
            out_last_r    <= (idx_r == 0);
            state_r       <= first_state(1'b0, 1'b0, idx_r);
          end
        end
        S_DATA: begin
          if (emit_ok) begin
            out_valid_r   <= 1'b1;
            out_is_data_r <= (kind_r != lcdnw_pkg::JOB_INIT);
            out_byte_r    <= data_byte;
            out_last_r    <= (idx_r == 4'd1);
            idx_r         <= idx_r - 4'd1;
            if (idx_r == 4'd1) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign wr.valid    = out_valid_r;
  assign wr.is_data  = out_is_data_r;
  assign wr.lcd_byte = out_byte_r;
  assign wr.last     = out_last_r;

endmodule

FILE: hw/rtl/char_lcd_number_writer.sv
// Top level of the character LCD number writer.
// Usage: each request on in_req (op, row, column, value, digit_count) is turned
// into the ordered byte writes for a two-line character LCD on out_wr, each
// tagged as command or data, with last set on the final byte of the request.
// Requests are accepted on valid && ready into a two-entry job queue, so
// in_req stays ready while the sequencer works, until the queue is full.
// An accepted request is registered in the queue and loaded from it by the
// idle sequencer; init and char requests then emit one byte per cycle while
// out_wr is ready (4 or up to 2 bytes). Number requests first run a
// shift-and-add-3 binary to BCD conversion, then emit address, sign and
// digits at one byte per cycle while out_wr is ready.
// A number request that yields no byte (unsigned, no address, zero digits)
// still runs the conversion.
// When out_wr stalls, the output register holds its byte and the sequencer
// waits; the queue keeps accepting requests until it fills.
// Reset (rst_n low, synchronous) empties the queue, idles the sequencer and
// drops any pending output byte.
module char_lcd_number_writer #(
  parameter int MAX_DIGITS = lcdnw_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lcdnw_req_if.sink   in_req,
  lcdnw_wr_if.source  out_wr
);

  lcdnw_pkg::job_t front_job;
  lcdnw_pkg::job_t q_job;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  assign in_req.ready = !q_full;

  lcdnw_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .op          (in_req.op),
    .row         (in_req.row),
    .column      (in_req.column),
    .value       (in_req.value),
    .digit_count (in_req.digit_count),
    .job         (front_job)
  );

  lcdnw_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_req.valid),
    .wr_job (front_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  lcdnw_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (q_job),
    .q_empty (q_empty),
    .pop     (q_pop),
    .wr      (out_wr)
  );

endmodule
